// File: design/two_pole_gaussian_filter_defines.svh
// Assertion macros for the two-pole Gaussian filter checker.
`ifndef TWO_POLE_GAUSSIAN_FILTER_DEFINES_SVH
`define TWO_POLE_GAUSSIAN_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("two_pole_gaussian_filter: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("two_pole_gaussian_filter: next-cycle check failed");

`endif

// File: design/tpg_pkg.sv
// Package: widths, register map and coefficient table of the two-pole Gaussian filter.
`timescale 1ns / 1ps

package tpg_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int COEF_WIDTH   = 32;
    localparam int COEF_FRAC    = 30;
    localparam int PERIOD_WIDTH = 6;
    localparam int MAX_PERIOD   = 40;
    localparam int NUM_TRIPLES  = 20;
    localparam int IDX_WIDTH    = 5;
    localparam int ADDR_WIDTH   = 3;
    localparam int DATA_WIDTH   = 32;

    // Register map: index of each register (byte address = 4 * index)
    localparam logic REG_PERIOD = 1'b0;

    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 6'd2;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [COEF_WIDTH-1:0]   t_coef;

    // Raw coefficient triples in units of 1e-6, one per even period 2..40
    localparam int TAB_B0 [NUM_TRIPLES] = '{
        834615, 722959, 578300, 457577, 365017, 295336, 242632, 202250, 170835, 146017,
        126125, 109966, 96680, 85633, 76357, 68496, 61779, 55996, 50984, 46612};
    localparam int TAB_A1 [NUM_TRIPLES] = '{
        172854, 299460, 479080, 647112, 791668, 913103, 1014847, 1100556, 1173357, 1235757,
        1289719, 1336777, 1378133, 1414738, 1447346, 1476567, 1502894, 1526729, 1548408,
        1568205};
    localparam int TAB_A2 [NUM_TRIPLES] = '{
        -7470, -22419, -57379, -104688, -156684, -208439, -257479, -302806, -344192, -381774,
        -415844, -446743, -474813, -500371, -523703, -545063, -564672, -582726, -599392,
        -614817};

endpackage

// File: design/two_pole_gaussian_filter.sv
// Top level: two-pole recursive Gaussian smoothing filter with APB period register.
`timescale 1ns / 1ps
//
// Usage
//   Samples (signed Q15.16) enter on the s_* stream, one per transfer; each sample
//   produces exactly one result on the m_* stream: m_tdata carries the filtered value,
//   m_tuser flags an invalid period (then m_tdata is zero and the history is held).
//   The period register (APB, byte address 0) selects the smoothing period; it must be
//   even and in 2..40. Write it only while no sample is in flight.
// Timing
//   Throughput: one sample per cycle while m_tready is high. The recursion
//   y = b0*x + a1*y1 + a2*y2 is combinational: three 32x32 multiplies, rounding
//   and a three-input add with saturation sit between the input register and the
//   result/history registers, which a sample enters once the result register is free.
// Reset
//   Synchronous, active low: both stages empty, history cleared to zero, period = 2.
// Backpressure
//   When m_tready is low the result holds in the output register; the input register
//   still takes one more sample, then s_tready drops until the result drains.
//
module two_pole_gaussian_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tpg_pkg::SAMPLE_WIDTH-1:0]  s_tdata,   // [31:0] sample
    // result stream out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tpg_pkg::SAMPLE_WIDTH-1:0]  m_tdata,   // [31:0] filtered
    output logic                              m_tuser,   // [0] invalid_period
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tpg_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [tpg_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic [tpg_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                              pready
);

    localparam int PROD_WIDTH = tpg_pkg::SAMPLE_WIDTH + tpg_pkg::COEF_WIDTH;
    localparam int RND_WIDTH  = PROD_WIDTH - tpg_pkg::COEF_FRAC;
    localparam int SUM_WIDTH  = RND_WIDTH + 2;

    localparam logic signed [PROD_WIDTH-1:0] ROUND_HALF =
        PROD_WIDTH'(1) <<< (tpg_pkg::COEF_FRAC - 1);
    localparam logic signed [SUM_WIDTH-1:0] SAT_MAX =
        SUM_WIDTH'((64'sd1 <<< (tpg_pkg::SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_WIDTH-1:0] SAT_MIN = -SAT_MAX - SUM_WIDTH'(1);

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [tpg_pkg::PERIOD_WIDTH-1:0] r_period;
    logic                             w_reg_sel;

    assign w_reg_sel = (paddr[2] == tpg_pkg::REG_PERIOD);
    assign pready    = 1'b1;
    assign prdata    = w_reg_sel ? tpg_pkg::DATA_WIDTH'(r_period) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= tpg_pkg::PERIOD_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_period <= pwdata[tpg_pkg::PERIOD_WIDTH-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Coefficient table: each triple normalized by its own sum at elaboration,
    // rounded half away from zero to COEF_FRAC fraction bits.
    // ---------------------------------------------------------------
    tpg_pkg::t_coef w_b0_tab [tpg_pkg::NUM_TRIPLES];
    tpg_pkg::t_coef w_a1_tab [tpg_pkg::NUM_TRIPLES];
    tpg_pkg::t_coef w_a2_tab [tpg_pkg::NUM_TRIPLES];

    for (genvar k = 0; k < tpg_pkg::NUM_TRIPLES; k++) begin : g_coef
        localparam longint Sum = longint'(tpg_pkg::TAB_B0[k]) + longint'(tpg_pkg::TAB_A1[k])
                               + longint'(tpg_pkg::TAB_A2[k]);
        localparam longint QB0 =
            ((longint'(tpg_pkg::TAB_B0[k]) <<< tpg_pkg::COEF_FRAC) + Sum / 2) / Sum;
        localparam longint QA1 =
            ((longint'(tpg_pkg::TAB_A1[k]) <<< tpg_pkg::COEF_FRAC) + Sum / 2) / Sum;
        localparam longint QA2 =
            -(((longint'(-tpg_pkg::TAB_A2[k]) <<< tpg_pkg::COEF_FRAC) + Sum / 2) / Sum);
        assign w_b0_tab[k] = tpg_pkg::COEF_WIDTH'(QB0);
        assign w_a1_tab[k] = tpg_pkg::COEF_WIDTH'(QA1);
        assign w_a2_tab[k] = tpg_pkg::COEF_WIDTH'(QA2);
    end

    // ---------------------------------------------------------------
    // Period decode
    // ---------------------------------------------------------------
    logic                          w_bad_period;
    logic [tpg_pkg::IDX_WIDTH-1:0] w_raw_idx;
    logic [tpg_pkg::IDX_WIDTH-1:0] w_idx;

    assign w_bad_period = (r_period < tpg_pkg::PERIOD_WIDTH'(2))
                       || (r_period > tpg_pkg::PERIOD_WIDTH'(tpg_pkg::MAX_PERIOD))
                       || r_period[0];
    assign w_raw_idx = r_period[tpg_pkg::PERIOD_WIDTH-1:1] - tpg_pkg::IDX_WIDTH'(1);
    // clamp so an invalid period never indexes past the table
    assign w_idx = (w_raw_idx >= tpg_pkg::IDX_WIDTH'(tpg_pkg::NUM_TRIPLES))
                 ? tpg_pkg::IDX_WIDTH'(tpg_pkg::NUM_TRIPLES - 1) : w_raw_idx;

    // ---------------------------------------------------------------
    // Handshake: input register -> result register
    // ---------------------------------------------------------------
    logic            r_in_vld;
    tpg_pkg::t_sample r_x;
    logic            r_out_vld;
    tpg_pkg::t_sample r_filtered;
    logic            r_invalid;
    tpg_pkg::t_sample r_y1;
    tpg_pkg::t_sample r_y2;
    logic            w_advance;
    logic            w_take;

    // move the held sample into the result register when that slot is free or draining
    assign w_advance = r_in_vld && (!r_out_vld || m_tready);
    assign s_tready  = !r_in_vld || w_advance;
    assign w_take    = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Filter datapath: three products, round, add, saturate
    // ---------------------------------------------------------------
    logic signed [PROD_WIDTH-1:0] w_p_b0, w_p_a1, w_p_a2;
    logic signed [RND_WIDTH-1:0]  w_r_b0, w_r_a1, w_r_a2;
    logic signed [SUM_WIDTH-1:0]  w_sum;
    tpg_pkg::t_sample             w_y;

    assign w_p_b0 = PROD_WIDTH'(w_b0_tab[w_idx]) * PROD_WIDTH'(r_x);
    assign w_p_a1 = PROD_WIDTH'(w_a1_tab[w_idx]) * PROD_WIDTH'(r_y1);
    assign w_p_a2 = PROD_WIDTH'(w_a2_tab[w_idx]) * PROD_WIDTH'(r_y2);

    // round half up, then drop the coefficient fraction
    assign w_r_b0 = RND_WIDTH'((w_p_b0 + ROUND_HALF) >>> tpg_pkg::COEF_FRAC);
    assign w_r_a1 = RND_WIDTH'((w_p_a1 + ROUND_HALF) >>> tpg_pkg::COEF_FRAC);
    assign w_r_a2 = RND_WIDTH'((w_p_a2 + ROUND_HALF) >>> tpg_pkg::COEF_FRAC);

    assign w_sum = SUM_WIDTH'(w_r_b0) + SUM_WIDTH'(w_r_a1) + SUM_WIDTH'(w_r_a2);

    always_comb begin
        priority if (w_sum > SAT_MAX) begin
            w_y = tpg_pkg::SAMPLE_WIDTH'(SAT_MAX);
        end else if (w_sum < SAT_MIN) begin
            w_y = tpg_pkg::SAMPLE_WIDTH'(SAT_MIN);
        end else begin
            w_y = w_sum[tpg_pkg::SAMPLE_WIDTH-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_y1      <= '0;
            r_y2      <= '0;
        end else begin
            if (w_take) begin
                r_in_vld <= 1'b1;
            end else if (w_advance) begin
                r_in_vld <= 1'b0;
            end

            if (w_advance) begin
                r_out_vld <= 1'b1;
            end else if (m_tready) begin
                r_out_vld <= 1'b0;
            end

            // shift the history only for a sample the filter really used
            if (w_advance && !w_bad_period) begin
                r_y1 <= w_y;
                r_y2 <= r_y1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_x <= s_tdata;
        end
        if (w_advance) begin
            r_filtered <= w_bad_period ? '0 : w_y;
            r_invalid  <= w_bad_period;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = r_filtered;
    assign m_tuser  = r_invalid;

endmodule

// File: design/tpg_checker.sv
// Port-level checker for the two-pole Gaussian filter, bound to the top level.
`timescale 1ns / 1ps
`include "two_pole_gaussian_filter_defines.svh"

module tpg_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              i_s_tready,
    input logic                              i_m_tvalid,
    input logic                              i_m_tready,
    input logic [tpg_pkg::SAMPLE_WIDTH-1:0]  i_m_tdata,
    input logic                              i_m_tuser
);

    // a stalled result holds its payload
    `TPG_ASSERT_NEXT(a_out_hold, i_m_tvalid && !i_m_tready,
        i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))

    // an invalid-period result carries zero
    `TPG_ASSERT_NOW(a_invalid_zero, i_m_tvalid && i_m_tuser, i_m_tdata == '0)

    // input side stalls only behind a full, stalled output
    `TPG_ASSERT_NOW(a_stall_cause, !i_s_tready, i_m_tvalid && !i_m_tready)

    // an accepted sample moves on to the output when the sink then drains
    `TPG_ASSERT_NEXT(a_latency, (i_s_tvalid && i_s_tready) ##1 i_m_tready, i_m_tvalid)

endmodule

bind two_pole_gaussian_filter tpg_checker u_tpg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_tvalid),
    .i_s_tready (s_tready),
    .i_m_tvalid (m_tvalid),
    .i_m_tready (m_tready),
    .i_m_tdata  (m_tdata),
    .i_m_tuser  (m_tuser)
);
